/* rtl/btt_pkg.sv */
package btt_pkg;

   localparam int OFFSET_BITS = 16;
   localparam int TOKEN_DEPTH = 4;
   localparam int TOKEN_PTR_BITS = $clog2(TOKEN_DEPTH);
   localparam int MAX_TOKENS = 3;

   localparam logic [15:0] LENGTH_MAX = 16'hFFFF;

   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DOT = 8'h2E;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_VTAB = 8'h0B;
   localparam logic [7:0] CH_FORMFEED = 8'h0C;
   localparam logic [7:0] CH_RETURN = 8'h0D;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_SLASH,
      MODE_COMMENT,
      MODE_STRING,
      MODE_IDENT,
      MODE_NUMBER
   } lexer_mode_type;

   typedef enum logic [2:0] {
      KIND_LBRACE = 3'd0,
      KIND_RBRACE = 3'd1,
      KIND_STRING = 3'd2,
      KIND_IDENT = 3'd3,
      KIND_NUMBER = 3'd4,
      KIND_ERROR = 3'd5,
      KIND_EOT = 3'd6
   } token_kind_type;

   typedef struct packed {
      token_kind_type kind;
      logic [15:0] start;
      logic [15:0] length;
      logic last;
   } token_type;

   function automatic logic is_space(input logic [7:0] b);
      return b == CH_SPACE || b == CH_TAB || b == CH_NEWLINE || b == CH_VTAB ||
             b == CH_FORMFEED || b == CH_RETURN;
   endfunction

   function automatic logic is_letter(input logic [7:0] b);
      return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return b >= 8'h30 && b <= 8'h39;
   endfunction

   function automatic logic is_ident_more(input logic [7:0] b);
      return is_letter(b) || is_digit(b) || b == CH_UNDERSCORE;
   endfunction

   function automatic logic is_number_byte(input logic [7:0] b);
      return is_digit(b) || b == CH_MINUS || b == CH_DOT;
   endfunction

   function automatic logic [15:0] sat_inc(input logic [15:0] len);
      return (len < LENGTH_MAX) ? 16'(len + 16'd1) : LENGTH_MAX;
   endfunction

   function automatic logic [15:0] to_start(input logic [OFFSET_BITS-1:0] offset);
      logic [31:0] wide;
      wide = 32'(offset);
      return wide[15:0];
   endfunction

endpackage

/* rtl/brace_text_tokenizer.sv */
// Brace-text tokenizer.
// The req_ channel carries one text byte per word; req_tlast marks the last
// byte of a text. The rsp_ channel carries one token per word: start offset
// and length in rsp_tdata, the token kind in rsp_tuser, with rsp_tlast set on
// the final token caused by a byte.
// After the last byte of a text an end-of-text token follows, and offsets
// start again from zero for the next text.
// A byte is decoded in the cycle it is accepted and its tokens (none to
// three) are written into a four-entry token queue; the first of them can
// be taken on the next cycle. One byte is accepted every cycle while the
// queue holds at most one token, so a stream giving at most one token per
// byte flows at one byte per cycle while the receiver is ready; a byte that
// gives two or three tokens holds off new bytes until the queue holds at most one token again.
// When the receiver stalls, the queue fills and req_tready falls until it
// drains; no token is lost or repeated.
// Reset empties the queue and returns the lexer to idle at offset zero.
module brace_text_tokenizer
   import btt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // in_byte
   input  logic        req_tlast,  // end_of_text
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // token_start[15:0], token_length[31:16]
   output logic [2:0]  rsp_tuser,  // token_kind[2:0]
   output logic        rsp_tlast   // last_of_run
);

   lexer_mode_type mode_ff, mode_in;
   logic [OFFSET_BITS-1:0] start_ff, start_in;
   logic [15:0] length_ff, length_in;
   logic [OFFSET_BITS-1:0] position_ff, position_in;

   token_type queue_ff [TOKEN_DEPTH];
   logic [TOKEN_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [TOKEN_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [TOKEN_PTR_BITS:0] count_ff, count_in;

   token_type tok [MAX_TOKENS];
   logic [1:0] tok_count;
   logic consumed;
   logic accept;
   logic pop;
   logic [7:0] b;
   token_type head;

   assign b = req_tdata;
   assign req_tready = (count_ff < (TOKEN_PTR_BITS + 1)'(2));
   assign accept = req_tvalid && req_tready;
   assign rsp_tvalid = (count_ff != '0);
   assign pop = rsp_tvalid && rsp_tready;
   assign head = queue_ff[rd_ptr_ff];
   assign rsp_tdata = {head.length, head.start};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

   always_comb begin
      mode_in = mode_ff;
      start_in = start_ff;
      length_in = length_ff;
      consumed = 1'b0;
      tok_count = 2'd0;
      for (int i = 0; i < MAX_TOKENS; i++) begin
         tok[i] = '{kind: KIND_EOT, start: 16'd0, length: 16'd0, last: 1'b0};
      end

      unique case (mode_ff)
         MODE_SLASH: begin
            if (b == CH_SLASH) begin
               mode_in = MODE_COMMENT;
               consumed = 1'b1;
            end else begin
               tok[tok_count] = '{KIND_ERROR, to_start(start_ff), 16'd1, 1'b0};
               tok_count = tok_count + 2'd1;
               mode_in = MODE_IDLE;
            end
         end
         MODE_COMMENT: begin
            if (b == CH_NEWLINE) begin
               mode_in = MODE_IDLE;
            end
            consumed = 1'b1;
         end
         MODE_STRING: begin
            if (b == CH_QUOTE) begin
               tok[tok_count] = '{KIND_STRING, to_start(start_ff), length_ff, 1'b0};
               tok_count = tok_count + 2'd1;
               mode_in = MODE_IDLE;
            end else begin
               length_in = sat_inc(length_ff);
            end
            consumed = 1'b1;
         end
         MODE_IDENT: begin
            if (is_ident_more(b)) begin
               length_in = sat_inc(length_ff);
               consumed = 1'b1;
            end else begin
               tok[tok_count] = '{KIND_IDENT, to_start(start_ff), length_ff, 1'b0};
               tok_count = tok_count + 2'd1;
               mode_in = MODE_IDLE;
            end
         end
         MODE_NUMBER: begin
            if (is_number_byte(b)) begin
               length_in = sat_inc(length_ff);
               consumed = 1'b1;
            end else begin
               tok[tok_count] = '{KIND_NUMBER, to_start(start_ff), length_ff, 1'b0};
               tok_count = tok_count + 2'd1;
               mode_in = MODE_IDLE;
            end
         end
         default: begin
            mode_in = MODE_IDLE;
         end
      endcase

      if (!consumed) begin
         priority if (is_space(b)) begin
            mode_in = mode_in;
         end else if (b == CH_LBRACE) begin
            tok[tok_count] = '{KIND_LBRACE, to_start(position_ff), 16'd1, 1'b0};
            tok_count = tok_count + 2'd1;
         end else if (b == CH_RBRACE) begin
            tok[tok_count] = '{KIND_RBRACE, to_start(position_ff), 16'd1, 1'b0};
            tok_count = tok_count + 2'd1;
         end else if (b == CH_QUOTE) begin
            mode_in = MODE_STRING;
            start_in = position_ff + OFFSET_BITS'(1);
            length_in = 16'd0;
         end else if (b == CH_SLASH) begin
            mode_in = MODE_SLASH;
            start_in = position_ff;
            length_in = 16'd1;
         end else if (is_letter(b) || b == CH_UNDERSCORE) begin
            mode_in = MODE_IDENT;
            start_in = position_ff;
            length_in = 16'd1;
         end else if (is_number_byte(b)) begin
            mode_in = MODE_NUMBER;
            start_in = position_ff;
            length_in = 16'd1;
         end else begin
            tok[tok_count] = '{KIND_ERROR, to_start(position_ff), 16'd1, 1'b0};
            tok_count = tok_count + 2'd1;
         end
      end

      if (req_tlast) begin
         unique case (mode_in)
            MODE_SLASH: begin
               tok[tok_count] = '{KIND_ERROR, to_start(start_in), 16'd1, 1'b0};
               tok_count = tok_count + 2'd1;
            end
            MODE_STRING: begin
               tok[tok_count] = '{KIND_ERROR, to_start(start_in), length_in, 1'b0};
               tok_count = tok_count + 2'd1;
            end
            MODE_IDENT: begin
               tok[tok_count] = '{KIND_IDENT, to_start(start_in), length_in, 1'b0};
               tok_count = tok_count + 2'd1;
            end
            MODE_NUMBER: begin
               tok[tok_count] = '{KIND_NUMBER, to_start(start_in), length_in, 1'b0};
               tok_count = tok_count + 2'd1;
            end
            default: begin
               mode_in = mode_in;
            end
         endcase
         tok[tok_count] = '{KIND_EOT, 16'd0, 16'd0, 1'b0};
         tok_count = tok_count + 2'd1;
         mode_in = MODE_IDLE;
         start_in = '0;
         length_in = 16'd0;
         position_in = '0;
      end else begin
         position_in = position_ff + OFFSET_BITS'(1);
      end

      if (tok_count != 2'd0) begin
         tok[tok_count - 2'd1].last = 1'b1;
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (accept) begin
         wr_ptr_in = wr_ptr_ff + TOKEN_PTR_BITS'(tok_count);
         count_in = count_in + (TOKEN_PTR_BITS + 1)'(tok_count);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + TOKEN_PTR_BITS'(1);
         count_in = count_in - (TOKEN_PTR_BITS + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         start_ff <= '0;
         length_ff <= 16'd0;
         position_ff <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (accept) begin
            mode_ff <= mode_in;
            start_ff <= start_in;
            length_ff <= length_in;
            position_ff <= position_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_TOKENS; i++) begin
         if (accept && (2'(i) < tok_count)) begin
            queue_ff[wr_ptr_ff + TOKEN_PTR_BITS'(i)] <= tok[i];
         end
      end
   end

endmodule

/* tb/sv/brace_text_tokenizer_tb.sv */
`timescale 1ns / 1ps

module brace_text_tokenizer_tb
   import btt_pkg::*;
();

   localparam int CLOCK_PERIOD = 10;
   localparam int RESET_CYCLES = 5;
   localparam int RANDOM_ITEMS = 380;
   localparam int HOLD_CYCLES = 120;
   localparam int DRAIN_CYCLES = 20;
   localparam int WATCHDOG_LIMIT = 2000;

   localparam logic [7:0] BLANK_BYTES [6] = '{CH_SPACE, CH_TAB, CH_NEWLINE, CH_VTAB,
                                              CH_FORMFEED, CH_RETURN};
   localparam logic [7:0] CLOSING_BYTES [6] = '{CH_QUOTE, CH_SLASH, CH_LBRACE, CH_RBRACE,
                                                CH_NEWLINE, CH_UNDERSCORE};

   typedef struct {
      token_kind_type kind;
      logic [15:0] start;
      logic [15:0] length;
      logic last;
   } lexed_token_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [7:0] req_tdata = 8'h00;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [2:0] rsp_tuser;
   logic rsp_tlast;

   lexed_token_type expected_tokens [$];
   lexed_token_type run_tokens [MAX_TOKENS];
   int run_count;
   lexer_mode_type lex_mode = MODE_IDLE;
   logic [OFFSET_BITS-1:0] tok_start = '0;
   logic [OFFSET_BITS-1:0] position = '0;
   logic [15:0] tok_length = '0;

   int errors = 0;
   int items_sent = 0;
   int burst_left = 0;
   bit gaps_on = 1'b1;
   bit rx_steady = 1'b0;
   bit hold_request = 1'b0;
   bit hold_active = 1'b0;

   brace_text_tokenizer DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic bit blank_char(input logic [7:0] b);
      return b inside {CH_SPACE, [CH_TAB:CH_RETURN]};
   endfunction

   function automatic bit ident_head_char(input logic [7:0] b);
      return b inside {[8'h41:8'h5A], [8'h61:8'h7A], CH_UNDERSCORE};
   endfunction

   function automatic bit ident_tail_char(input logic [7:0] b);
      return ident_head_char(b) || (b inside {[8'h30:8'h39]});
   endfunction

   function automatic bit numeral_char(input logic [7:0] b);
      return b inside {[8'h30:8'h39], CH_MINUS, CH_DOT};
   endfunction

   function automatic void note_token(input token_kind_type kind,
                                      input logic [OFFSET_BITS-1:0] start,
                                      input logic [15:0] length);
      run_tokens[run_count].kind = kind;
      run_tokens[run_count].start = 16'(start);
      run_tokens[run_count].length = length;
      run_tokens[run_count].last = 1'b0;
      run_count++;
   endfunction

   function automatic void tokenize_byte(input logic [7:0] b, input logic eot);
      lexed_token_type t;
      logic taken;
      taken = 1'b0;
      run_count = 0;
      case (lex_mode)
         MODE_SLASH: begin
            if (b == CH_SLASH) begin
               lex_mode = MODE_COMMENT;
               taken = 1'b1;
            end else begin
               note_token(KIND_ERROR, tok_start, 16'd1);
               lex_mode = MODE_IDLE;
            end
         end
         MODE_COMMENT: begin
            if (b == CH_NEWLINE)
               lex_mode = MODE_IDLE;
            taken = 1'b1;
         end
         MODE_STRING: begin
            if (b == CH_QUOTE) begin
               note_token(KIND_STRING, tok_start, tok_length);
               lex_mode = MODE_IDLE;
            end else if (tok_length != LENGTH_MAX) begin
               tok_length++;
            end
            taken = 1'b1;
         end
         MODE_IDENT: begin
            if (ident_tail_char(b)) begin
               if (tok_length != LENGTH_MAX)
                  tok_length++;
               taken = 1'b1;
            end else begin
               note_token(KIND_IDENT, tok_start, tok_length);
               lex_mode = MODE_IDLE;
            end
         end
         MODE_NUMBER: begin
            if (numeral_char(b)) begin
               if (tok_length != LENGTH_MAX)
                  tok_length++;
               taken = 1'b1;
            end else begin
               note_token(KIND_NUMBER, tok_start, tok_length);
               lex_mode = MODE_IDLE;
            end
         end
         default: begin
            lex_mode = MODE_IDLE;
         end
      endcase

      if (!taken && !blank_char(b)) begin
         if (b == CH_LBRACE) begin
            note_token(KIND_LBRACE, position, 16'd1);
         end else if (b == CH_RBRACE) begin
            note_token(KIND_RBRACE, position, 16'd1);
         end else if (b == CH_QUOTE) begin
            lex_mode = MODE_STRING;
            tok_start = position + OFFSET_BITS'(1);
            tok_length = 16'd0;
         end else if (b == CH_SLASH) begin
            lex_mode = MODE_SLASH;
            tok_start = position;
            tok_length = 16'd1;
         end else if (ident_head_char(b)) begin
            lex_mode = MODE_IDENT;
            tok_start = position;
            tok_length = 16'd1;
         end else if (numeral_char(b)) begin
            lex_mode = MODE_NUMBER;
            tok_start = position;
            tok_length = 16'd1;
         end else begin
            note_token(KIND_ERROR, position, 16'd1);
         end
      end

      if (eot) begin
         case (lex_mode)
            MODE_SLASH: note_token(KIND_ERROR, tok_start, 16'd1);
            MODE_STRING: note_token(KIND_ERROR, tok_start, tok_length);
            MODE_IDENT: note_token(KIND_IDENT, tok_start, tok_length);
            MODE_NUMBER: note_token(KIND_NUMBER, tok_start, tok_length);
            default: begin
            end
         endcase
         note_token(KIND_EOT, '0, 16'd0);
         lex_mode = MODE_IDLE;
         tok_start = '0;
         tok_length = 16'd0;
         position = '0;
      end else begin
         position = position + OFFSET_BITS'(1);
      end

      for (int i = 0; i < run_count; i++) begin
         t = run_tokens[i];
         t.last = (i == run_count - 1);
         expected_tokens.push_back(t);
      end
   endfunction

   always @(posedge clock) begin : check_tokens
      lexed_token_type want;
      if (!reset) begin
         if (req_tvalid && req_tready)
            tokenize_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_tokens.size() == 0) begin
               $error("token word with none expected: kind %0d start %0d length %0d",
                      rsp_tuser, rsp_tdata[15:0], rsp_tdata[31:16]);
               errors++;
            end else begin
               want = expected_tokens.pop_front();
               if (rsp_tuser !== want.kind) begin
                  $error("token_kind: expected %0d, got %0d", want.kind, rsp_tuser);
                  errors++;
               end
               if (rsp_tdata[15:0] !== want.start) begin
                  $error("token_start: expected %0d, got %0d", want.start, rsp_tdata[15:0]);
                  errors++;
               end
               if (rsp_tdata[31:16] !== want.length) begin
                  $error("token_length: expected %0d, got %0d", want.length,
                         rsp_tdata[31:16]);
                  errors++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last_of_run: expected %0d, got %0d", want.last, rsp_tlast);
                  errors++;
               end
            end
         end
      end
   end

   // The receiver alternates ready and stalled stretches of random length,
   // unless it is told to stay ready or to hold off for a long while.
   initial begin : token_receiver
      bit rx_on;
      int rx_count;
      rx_on = 1'b0;
      rx_count = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_active = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_active = 1'b0;
         end else if (rx_steady) begin
            rsp_tready <= 1'b1;
         end else begin
            if (rx_count == 0) begin
               rx_on = !rx_on;
               rx_count = rx_on ? $urandom_range(1, 10) : $urandom_range(1, 5);
            end
            rx_count--;
            rsp_tready <= rx_on;
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("[brace_text_tokenizer] ERROR");
      $finish;
   end

   task automatic send_byte(input logic [7:0] b, input logic eot);
      if (gaps_on && burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 16);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= eot;
      do
         @(posedge clock);
      while (!req_tready);
      if (burst_left > 0)
         burst_left--;
      items_sent++;
   endtask

   task automatic sender_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_text(input string text);
      for (int i = 0; i < text.len(); i++)
         send_byte(text[i], i == text.len() - 1);
   endtask

   function automatic logic [7:0] pick_text_byte(input logic [7:0] avoid);
      logic [7:0] b;
      if ($urandom_range(0, 3) == 0)
         b = 8'($urandom_range(0, 255));
      else
         b = 8'($urandom_range(32, 126));
      if (b == avoid)
         b = 8'h41;
      return b;
   endfunction

   task automatic send_identifier(input int len);
      int r;
      r = $urandom_range(0, 52);
      send_byte(r < 26 ? 8'(8'h61 + r) : r < 52 ? 8'(8'h41 + r - 26) : CH_UNDERSCORE, 1'b0);
      for (int i = 1; i < len; i++) begin
         r = $urandom_range(0, 62);
         send_byte(r < 26 ? 8'(8'h61 + r) : r < 52 ? 8'(8'h41 + r - 26) :
                   r < 62 ? 8'(8'h30 + r - 52) : CH_UNDERSCORE, 1'b0);
      end
   endtask

   task automatic send_number(input int len);
      int r;
      for (int i = 0; i < len; i++) begin
         r = $urandom_range(0, 11);
         send_byte(r < 10 ? 8'(8'h30 + r) : r == 10 ? CH_MINUS : CH_DOT, 1'b0);
      end
   endtask

   task automatic test_basic_tokens();
      gaps_on = 1'b1;
      rx_steady = 1'b0;
      send_text("{_Z9 -2.5\"s\"}");
   endtask

   task automatic test_comments_and_slashes();
      send_text("/a//c\n/");
   endtask

   task automatic test_unknown_and_unterminated();
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(CH_VTAB, 1'b0);
      send_byte(CH_QUOTE, 1'b0);
      send_byte("z", 1'b1);
      send_byte(CH_QUOTE, 1'b1);
      send_byte(CH_SPACE, 1'b1);
   endtask

   task automatic test_backpressure();
      sender_idle();
      gaps_on = 1'b0;
      hold_request = 1'b1;
      while (!hold_active)
         @(posedge clock);
      for (int i = 0; i < 12; i++) begin
         send_byte("a", 1'b0);
         send_byte(i % 2 ? CH_RBRACE : CH_LBRACE, i == 11);
      end
   endtask

   task automatic send_random_text();
      int token_count;
      logic [7:0] b;
      token_count = $urandom_range(0, 8);
      if ($urandom_range(0, 3) == 0) begin
         gaps_on = 1'b0;
         rx_steady = 1'b1;
      end else begin
         gaps_on = 1'b1;
         rx_steady = 1'b0;
      end
      for (int t = 0; t < token_count; t++) begin
         case ($urandom_range(0, 9))
            0: repeat ($urandom_range(1, 3)) send_byte(BLANK_BYTES[$urandom_range(0, 5)], 1'b0);
            1: send_byte(CH_LBRACE, 1'b0);
            2: send_byte(CH_RBRACE, 1'b0);
            3: begin
               send_byte(CH_QUOTE, 1'b0);
               repeat ($urandom_range(0, 6)) send_byte(pick_text_byte(CH_QUOTE), 1'b0);
               send_byte(CH_QUOTE, 1'b0);
            end
            4: send_identifier($urandom_range(1, 8));
            5: send_number($urandom_range(1, 6));
            6: begin
               send_byte(CH_SLASH, 1'b0);
               send_byte(CH_SLASH, 1'b0);
               repeat ($urandom_range(0, 6)) send_byte(pick_text_byte(CH_NEWLINE), 1'b0);
               send_byte(CH_NEWLINE, 1'b0);
            end
            7: send_byte(CH_SLASH, 1'b0);
            8: begin
               do
                  b = 8'($urandom_range(0, 255));
               while (blank_char(b) || ident_tail_char(b) || numeral_char(b) ||
                      b inside {CH_LBRACE, CH_RBRACE, CH_QUOTE, CH_SLASH});
               send_byte(b, 1'b0);
            end
            default: repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)), 1'b0);
         endcase
      end

      // Texts often end inside a token, so that every end-of-text case is met.
      case ($urandom_range(0, 5))
         1: begin
            send_byte(CH_QUOTE, 1'b0);
            repeat ($urandom_range(0, 3)) send_byte(pick_text_byte(CH_QUOTE), 1'b0);
         end
         2: send_byte(CH_SLASH, 1'b0);
         3: begin
            send_byte(CH_SLASH, 1'b0);
            send_byte(CH_SLASH, 1'b0);
            repeat ($urandom_range(0, 3)) send_byte(pick_text_byte(CH_NEWLINE), 1'b0);
         end
         4: send_identifier($urandom_range(1, 3));
         5: send_number($urandom_range(1, 3));
         default: begin
         end
      endcase
      case ($urandom_range(0, 3))
         0: b = 8'($urandom_range(0, 255));
         1: b = CLOSING_BYTES[$urandom_range(0, 5)];
         2: b = 8'(8'h61 + $urandom_range(0, 25));
         default: b = $urandom_range(0, 1) ? CH_DOT : 8'(8'h30 + $urandom_range(0, 9));
      endcase
      send_byte(b, 1'b1);
   endtask

   task automatic test_random_texts();
      int first_item;
      first_item = items_sent;
      while (items_sent - first_item < RANDOM_ITEMS)
         send_random_text();
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_basic_tokens();
      test_comments_and_slashes();
      test_unknown_and_unterminated();
      test_backpressure();
      test_random_texts();
      sender_idle();
      while (expected_tokens.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("[brace_text_tokenizer] OK");
      else
         $display("[brace_text_tokenizer] ERROR");
      $finish;
   end

endmodule
